### rtl/volume_median_filter_3x3x3_assert.svh
`ifndef VOLUME_MEDIAN_FILTER_3X3X3_ASSERT_SVH
`define VOLUME_MEDIAN_FILTER_3X3X3_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define VMF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define VMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/vmf_pkg.sv
package vmf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COORD_W     = 5;
  localparam int EDGE_W      = 6;
  localparam int MAX_EDGE    = 32;
  localparam int ADDR_W      = 3 * COORD_W;
  localparam int STORE_DEPTH = MAX_EDGE * MAX_EDGE * MAX_EDGE;

  // The median of 27 is the largest of the 14 smallest values.
  localparam int MID_RANK    = 13;
  localparam int KEEP        = MID_RANK + 1;
  localparam int KEEP_IDX_W  = $clog2(KEEP);
  localparam int KEEP_CNT_W  = $clog2(KEEP + 1);

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic clear;
    logic load;
  } sel_cmd_t;

  typedef struct packed {
    logic busy;
  } sel_stat_t;

endpackage

### rtl/vmf_select.sv
module vmf_select (
  input  logic             clk,
  input  logic             rst_n,
  input  vmf_pkg::sel_cmd_t  cmd_i,
  input  vmf_pkg::sample_t   key_i,
  output vmf_pkg::sel_stat_t stat_o,
  output vmf_pkg::sample_t   median_o
);
  import vmf_pkg::*;

  sample_t                 s_r [KEEP];
  sample_t                 key_r;
  logic [KEEP_IDX_W-1:0]   p_r;
  logic [KEEP_CNT_W-1:0]   cnt_r;
  logic                    busy_r;
  logic                    first_r;

  logic [KEEP_IDX_W-1:0]   cmp_idx;
  logic                    gt;
  logic                    full;
  logic                    place;
  logic                    shift;
  logic                    wr_en;
  sample_t                 wr_data;

  assign full = (cnt_r == KEEP_CNT_W'(KEEP));

  // One comparator: against the top slot on a full list, else the slot below the hole.
  assign cmp_idx = (first_r || p_r == '0) ? KEEP_IDX_W'(KEEP - 1) : p_r - 1'b1;
  assign gt      = s_r[cmp_idx] > key_r;

  assign place   = busy_r && !first_r && (p_r == '0 || !gt);
  assign shift   = busy_r && !first_r && p_r != '0 && gt;
  assign wr_en   = place || shift;
  assign wr_data = place ? key_r : s_r[cmp_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      first_r <= 1'b0;
      cnt_r   <= '0;
      p_r     <= '0;
    end else if (cmd_i.clear) begin
      cnt_r <= '0;
    end else if (cmd_i.load) begin
      busy_r <= 1'b1;
      if (full) begin
        p_r     <= KEEP_IDX_W'(KEEP - 1);
        first_r <= 1'b1;
      end else begin
        p_r     <= KEEP_IDX_W'(cnt_r);
        first_r <= 1'b0;
      end
    end else if (busy_r) begin
      if (first_r) begin
        // drop the key if it is not below the current top, else evict the top
        first_r <= 1'b0;
        if (!gt) begin
          busy_r <= 1'b0;
        end
      end else if (place) begin
        busy_r <= 1'b0;
        if (!full) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end else begin
        p_r <= p_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      key_r <= key_i;
    end
    if (wr_en) begin
      s_r[p_r] <= wr_data;
    end
  end

  assign stat_o.busy = busy_r;
  assign median_o    = s_r[KEEP-1];

endmodule

### rtl/volume_median_filter_3x3x3.sv
// 3x3x3 median filter over a cubic volume of signed Q8.8 samples.
// Input channel: a transaction is taken on a clock edge with start high and
// busy low. in_func selects a write (in_sample stored at the voxel) or a
// query (median of the 27 mirrored neighbors of the voxel). Coordinates at
// or above the edge length are clamped to the last voxel.
// Result channel: out_valid is high for exactly one cycle with
// out_median_value; the receiver cannot stall it, so it must take it then.
// Configuration: cfg_wr_en writes cfg_wr_data into the edge length register
// (reset 32, used as 2..32); write only while busy is low.
// Timing: a write does not raise busy. A query keeps busy high while each
// neighbor is read from the single-port volume memory and inserted into a
// 14-entry sorted list by one comparator that moves one slot per cycle. The
// result strobes in the cycle busy falls. Reset returns the sequencer to
// idle and the edge length to 32; the volume contents are undefined until
// written.
module volume_median_filter_3x3x3 (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_func,
  input  logic [vmf_pkg::COORD_W-1:0]         in_coord_x,
  input  logic [vmf_pkg::COORD_W-1:0]         in_coord_y,
  input  logic [vmf_pkg::COORD_W-1:0]         in_coord_z,
  input  logic signed [vmf_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  output logic signed [vmf_pkg::SAMPLE_W-1:0] out_median_value,
  input  logic                                cfg_wr_en,
  input  logic [vmf_pkg::EDGE_W-1:0]          cfg_wr_data
);
  import vmf_pkg::*;

  `include "volume_median_filter_3x3x3_assert.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_WAIT
  } state_t;

  function automatic logic [COORD_W-1:0] clamp_coord(logic [COORD_W-1:0] c,
                                                     logic [EDGE_W-1:0]  e);
    logic [EDGE_W-1:0] last;
    last = e - 1'b1;
    return ({1'b0, c} >= e) ? last[COORD_W-1:0] : c;
  endfunction

  // d is the offset plus one; mirror without repeating the edge voxel
  function automatic logic [COORD_W-1:0] mirror(logic [COORD_W-1:0] c,
                                                logic [1:0]         d,
                                                logic [EDGE_W-1:0]  e);
    logic [EDGE_W-1:0] last;
    logic [EDGE_W-1:0] back;
    logic [COORD_W-1:0] r;
    last = e - 1'b1;
    back = e - 2'd2;
    case (d)
      2'd0:    r = (c == '0) ? COORD_W'(1) : c - 1'b1;
      2'd2:    r = ({1'b0, c} == last) ? back[COORD_W-1:0] : c + 1'b1;
      default: r = c;
    endcase
    return r;
  endfunction

  state_t               state_r;
  logic [EDGE_W-1:0]    edge_r;
  logic [EDGE_W-1:0]    edge_eff;
  logic [COORD_W-1:0]   x_r, y_r, z_r;
  logic [1:0]           dx_r, dy_r, dz_r;
  logic                 out_valid_r;
  sample_t              out_median_r;

  logic [COORD_W-1:0]   cx, cy, cz;
  logic                 accept;
  logic                 wr_go;
  logic                 last_nb;
  logic [ADDR_W-1:0]    nb_addr;
  logic [ADDR_W-1:0]    mem_addr;
  logic                 mem_re;
  sample_t              mem [STORE_DEPTH];
  sample_t              rd_data_r;

  sel_cmd_t             sel_cmd;
  sel_stat_t            sel_stat;
  sample_t              sel_median;

  always_comb begin
    if (edge_r < EDGE_W'(2)) begin
      edge_eff = EDGE_W'(2);
    end else if (edge_r > EDGE_W'(MAX_EDGE)) begin
      edge_eff = EDGE_W'(MAX_EDGE);
    end else begin
      edge_eff = edge_r;
    end
  end

  assign cx      = clamp_coord(in_coord_x, edge_eff);
  assign cy      = clamp_coord(in_coord_y, edge_eff);
  assign cz      = clamp_coord(in_coord_z, edge_eff);
  assign accept  = start && (state_r == ST_IDLE);
  assign wr_go   = accept && (in_func == FUNC_WRITE);
  assign last_nb = (dx_r == 2'd2) && (dy_r == 2'd2) && (dz_r == 2'd2);
  assign nb_addr = {mirror(x_r, dx_r, edge_eff), mirror(y_r, dy_r, edge_eff),
                    mirror(z_r, dz_r, edge_eff)};
  assign mem_re   = (state_r == ST_READ);
  assign mem_addr = wr_go ? {cx, cy, cz} : nb_addr;

  assign sel_cmd.clear = accept && (in_func == FUNC_QUERY);
  assign sel_cmd.load  = (state_r == ST_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_r <= EDGE_W'(MAX_EDGE);
    end else if (cfg_wr_en) begin
      edge_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go) begin
      mem[mem_addr] <= in_sample;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      out_median_r <= '0;
      x_r          <= '0;
      y_r          <= '0;
      z_r          <= '0;
      dx_r         <= '0;
      dy_r         <= '0;
      dz_r         <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept && in_func == FUNC_QUERY) begin
            x_r     <= cx;
            y_r     <= cy;
            z_r     <= cz;
            dx_r    <= '0;
            dy_r    <= '0;
            dz_r    <= '0;
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (!sel_stat.busy) begin
            if (last_nb) begin
              out_valid_r  <= 1'b1;
              out_median_r <= sel_median;
              state_r      <= ST_IDLE;
            end else begin
              // advance z fastest, then y, then x
              if (dz_r == 2'd2) begin
                dz_r <= '0;
                if (dy_r == 2'd2) begin
                  dy_r <= '0;
                  dx_r <= dx_r + 1'b1;
                end else begin
                  dy_r <= dy_r + 1'b1;
                end
              end else begin
                dz_r <= dz_r + 1'b1;
              end
              state_r <= ST_READ;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  vmf_select u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_i    (sel_cmd),
    .key_i    (rd_data_r),
    .stat_o   (sel_stat),
    .median_o (sel_median)
  );

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_median_value = out_median_r;

  `VMF_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe held past one cycle")
  `VMF_ASSERT_NEXT(a_write_no_result, start && !busy && in_func == FUNC_WRITE, !out_valid && !busy, "write transaction raised busy or a result")
  `VMF_ASSERT_NEXT(a_query_busy, start && !busy && in_func == FUNC_QUERY, busy && !out_valid, "query transaction did not start")
  `VMF_ASSERT_NOW(a_sel_in_wait, sel_stat.busy, state_r == ST_WAIT, "insertion running outside wait state")

endmodule

### verif/tb_volume_median_filter_3x3x3.sv
`timescale 1ns / 1ps

module tb_volume_median_filter_3x3x3;
  import vmf_pkg::*;

  localparam int LIMIT_CYCLES  = 3_000_000;
  localparam int ITEM_TARGET   = 1200;
  localparam int SETTLE_CYCLES = 8;
  localparam int SHOWN_ERRORS  = 10;

  // Tracks the volume contents and edge length, and queues the median each
  // accepted query must return.
  class median_tracker;
    sample_t           volume[STORE_DEPTH];
    bit                written[STORE_DEPTH];
    logic [EDGE_W-1:0] edge_reg;
    sample_t           medians_due[$];
    int unsigned       gaps[$];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       writes;

    function new();
      edge_reg   = 6'd32;
      mismatches = 0;
      checked    = 0;
      writes     = 0;
    endfunction

    function void set_edge(logic [EDGE_W-1:0] value);
      edge_reg = value;
    endfunction

    function int active_edge();
      int e;
      e = edge_reg;
      if (e < 2) e = 2;
      if (e > MAX_EDGE) e = MAX_EDGE;
      return e;
    endfunction

    function int clamp(int c, int e);
      return (c >= e) ? e - 1 : c;
    endfunction

    // Reflect about the border without repeating the border voxel.
    function int mirror(int c, int e);
      if (c < 0) return -c;
      if (c >= e) return 2 * (e - 1) - c;
      return c;
    endfunction

    function int unsigned locate(int x, int y, int z);
      return (x * MAX_EDGE + y) * MAX_EDGE + z;
    endfunction

    function int pending();
      return medians_due.size();
    endfunction

    // Collect the neighbor entries of a query that were never written.
    function int find_gaps(int xr, int yr, int zr);
      int e, x, y, z;
      int unsigned a;
      e = active_edge();
      x = clamp(xr, e);
      y = clamp(yr, e);
      z = clamp(zr, e);
      gaps.delete();
      for (int dx = -1; dx <= 1; dx++)
        for (int dy = -1; dy <= 1; dy++)
          for (int dz = -1; dz <= 1; dz++) begin
            a = locate(mirror(x + dx, e), mirror(y + dy, e), mirror(z + dz, e));
            if (!written[a]) gaps.push_back(a);
          end
      return gaps.size();
    endfunction

    function sample_t neighborhood_median(int x, int y, int z);
      int e, n, key, j;
      int vals[27];
      e = active_edge();
      n = 0;
      for (int dx = -1; dx <= 1; dx++)
        for (int dy = -1; dy <= 1; dy++)
          for (int dz = -1; dz <= 1; dz++) begin
            vals[n] = volume[locate(mirror(x + dx, e), mirror(y + dy, e), mirror(z + dz, e))];
            n++;
          end
      for (int i = 1; i < 27; i++) begin
        key = vals[i];
        j = i - 1;
        while (j >= 0 && vals[j] > key) begin
          vals[j + 1] = vals[j];
          j--;
        end
        vals[j + 1] = key;
      end
      return sample_t'(vals[MID_RANK]);
    endfunction

    function void note_item(logic func, int xr, int yr, int zr, sample_t smp);
      int e, x, y, z;
      int unsigned a;
      e = active_edge();
      x = clamp(xr, e);
      y = clamp(yr, e);
      z = clamp(zr, e);
      if (func == FUNC_WRITE) begin
        a = locate(x, y, z);
        volume[a]  = smp;
        written[a] = 1'b1;
        writes++;
      end else begin
        medians_due.push_back(neighborhood_median(x, y, z));
      end
    endfunction

    function void check_result(sample_t got);
      sample_t want;
      if (medians_due.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("[%0t] median %0d arrived with no query outstanding", $time, got);
        return;
      end
      want = medians_due.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("[%0t] median mismatch: expected %0d, got %0d", $time, want, got);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_func;
  logic [COORD_W-1:0]  in_coord_x;
  logic [COORD_W-1:0]  in_coord_y;
  logic [COORD_W-1:0]  in_coord_z;
  sample_t             in_sample;
  logic                out_valid;
  sample_t             out_median_value;
  logic                cfg_wr_en;
  logic [EDGE_W-1:0]   cfg_wr_data;

  median_tracker sb = new();
  int unsigned   cycles = 0;
  int unsigned   items_sent = 0;
  bit            sender_gaps = 1'b1;

  volume_median_filter_3x3x3 dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_coord_z       (in_coord_z),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_median_value (out_median_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d medians outstanding", cycles, sb.pending());
      $display("FAIL volume_median_filter_3x3x3");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_median_value);
  end

  task automatic pause_sender(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_item(logic func, int x, int y, int z, sample_t smp);
    @(negedge clk);
    in_func    <= func;
    in_coord_x <= x[COORD_W-1:0];
    in_coord_y <= y[COORD_W-1:0];
    in_coord_z <= z[COORD_W-1:0];
    in_sample  <= smp;
    start      <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(func, x, y, z, smp);
    items_sent++;
    if (sender_gaps && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 3));
  endtask

  // Hold off until every median has come back and the block is idle.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_edge(logic [EDGE_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_edge(value);
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 3))
      0: return sample_t'($urandom_range(0, 4) - 2);
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Mostly near the window base; now and then anywhere, clamped or not.
  function automatic int pick_coord(int base);
    int v;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 31);
    v = base + $urandom_range(0, 3);
    return (v > 31) ? 31 : v;
  endfunction

  task automatic run_sequence(int bx, int by, int bz);
    int x, y, z;
    int unsigned a;
    int unsigned fill[$];
    x = pick_coord(bx);
    y = pick_coord(by);
    z = pick_coord(bz);
    repeat ($urandom_range(0, 2))
      send_item(FUNC_WRITE, pick_coord(bx), pick_coord(by), pick_coord(bz), pick_sample());
    void'(sb.find_gaps(x, y, z));
    fill = sb.gaps;
    foreach (fill[i]) begin
      a = fill[i];
      send_item(FUNC_WRITE, (a >> 10) & 31, (a >> 5) & 31, a & 31, pick_sample());
    end
    // Leave some neighborhoods filled but never queried.
    if ($urandom_range(0, 7) != 0) send_item(FUNC_QUERY, x, y, z, pick_sample());
  endtask

  initial begin
    sample_t           low_corner[8];
    sample_t           high_corner[8];
    logic [EDGE_W-1:0] edges[$];
    int                per_phase, phase_end, e, bx, by, bz, k;

    low_corner  = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff,
                    16'sh0100, 16'shff00, 16'sh0001, 16'sh0064};
    high_corner = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh0005,
                    16'shfffb, 16'sh7fff, 16'sh8000, 16'sh0000};
    edges = '{6'd2, 6'd0, 6'd3, 6'd1, 6'd63, 6'd6, 6'd33, 6'd4, 6'd32, 6'd2};
    repeat (3) edges.push_back($urandom_range(0, 63));

    rst_n       = 1'b0;
    start       = 1'b0;
    in_func     = FUNC_WRITE;
    in_coord_x  = '0;
    in_coord_y  = '0;
    in_coord_z  = '0;
    in_sample   = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Both corners of the full-size cube, with the sample extremes.
    k = 0;
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        for (int l = 0; l < 2; l++) begin
          send_item(FUNC_WRITE, i, j, l, low_corner[k]);
          k++;
        end
    send_item(FUNC_QUERY, 0, 0, 0, 16'sh0000);
    k = 0;
    for (int i = 30; i < 32; i++)
      for (int j = 30; j < 32; j++)
        for (int l = 30; l < 32; l++) begin
          send_item(FUNC_WRITE, i, j, l, high_corner[k]);
          k++;
        end
    send_item(FUNC_QUERY, 31, 31, 31, 16'shffff);
    drain();

    per_phase = ITEM_TARGET / edges.size();
    foreach (edges[p]) begin
      write_edge(edges[p]);
      if (p == edges.size() - 1) sender_gaps = 1'b0;
      e = sb.active_edge();
      bx = $urandom_range(0, e - 1);
      by = $urandom_range(0, e - 1);
      bz = $urandom_range(0, e - 1);
      phase_end = items_sent + per_phase;
      while (items_sent < phase_end) begin
        run_sequence(bx, by, bz);
        if ($urandom_range(0, 15) == 0) begin
          bx = $urandom_range(0, e - 1);
          by = $urandom_range(0, e - 1);
          bz = $urandom_range(0, e - 1);
        end
        if (sender_gaps && $urandom_range(0, 39) == 0) drain();
      end
    end
    drain();

    $display("Sent %0d transactions: %0d voxel writes, %0d medians checked", items_sent,
             sb.writes, sb.checked);
    $display("Edge settings used: %0d, including out-of-range values; %0d mismatches",
             edges.size() + 1, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS volume_median_filter_3x3x3");
    end else begin
      $display("FAIL volume_median_filter_3x3x3");
    end
    $finish;
  end

endmodule
